[rtl/core/epfm_pkg.sv]
// Shared constants and control types for the edge period and frequency meter.
package epfm_pkg;

  localparam int unsigned COUNTER_BITS_DEFAULT = 16;
  localparam int unsigned TPS_BITS             = 24;
  localparam int unsigned FRAC_BITS            = 8;
  localparam int unsigned DIV_BITS             = TPS_BITS + FRAC_BITS;
  localparam int unsigned PERIOD_BITS          = 16;
  localparam int unsigned FREQ_BITS            = 32;
  localparam int unsigned STATUS_BITS          = 2;
  localparam int unsigned IN_DATA_BITS         = 8;
  localparam int unsigned OUT_DATA_BITS        = PERIOD_BITS + FREQ_BITS;

  localparam logic [TPS_BITS-1:0] TPS_RESET = TPS_BITS'(1000000);

  localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_WRAP = 2'd2;

  typedef struct packed {
    logic accept;    // input request taken this cycle
    logic div_step;  // one quotient bit
    logic load_out;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic result;    // offered request carries the closing edge
    logic error;     // that result carries no division
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

[rtl/core/edge_period_frequency_meter_core.sv]
// Edge period and frequency meter: top level joining sequencer and datapath.
//
// One input request per prescaled timer tick on s_*; s_tdata[0] flags a rising
// edge of the measured signal in that tick. The first edge captures the tick
// counter, the closing edge reports period and frequency, clears the counter
// and disarms. cfg_* writes the reference tick rate (reset value 1000000); it
// is always ready. It must be written only while the meter is idle; the block
// itself does not enforce this. A tick without a result is taken in the idle
// state and leaves the sequencer idle. The reporting tick starts a restoring
// divider that yields one quotient bit per cycle. An error result (wrap or zero
// period) skips the divider and goes straight from idle to the done state.
// The divider loop has 32 steps, one for each quotient bit.
// m_* holds its result until taken; the next tick is accepted while it waits,
// but a new result waits in the sequencer until the output register frees.
// Synchronous reset clears counter, capture, arm state and output valid.
module edge_period_frequency_meter_core #(
  parameter int unsigned COUNTER_BITS = epfm_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [epfm_pkg::TPS_BITS-1:0]       cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [epfm_pkg::IN_DATA_BITS-1:0]   s_tdata,   // [0] rising_edge
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [epfm_pkg::OUT_DATA_BITS-1:0]  m_tdata,   // [15:0] period_ticks, [47:16] frequency_q8
  output logic [epfm_pkg::STATUS_BITS-1:0]    m_tuser    // [1:0] status
);
  import epfm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  epfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  epfm_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .rising_edge (s_tdata[0]),
    .cmd         (cmd),
    .sts         (sts),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

`ifndef SYNTH
  a_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && sts.result |=> !s_tready)
    else $error("input still ready after a reporting request");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == '0))
    else $error("error result carries nonzero fields");

  a_ok_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_OK) |-> (m_tdata[PERIOD_BITS-1:0] != '0))
    else $error("valid result with zero period");
`endif

endmodule

[rtl/core/epfm_ctrl.sv]
// Sequencer for the edge period and frequency meter: accept, divide, deliver.
module epfm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  epfm_pkg::sts_t     sts,
  output epfm_pkg::cmd_t     cmd
);
  import epfm_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  state_t          state;
  logic [CntW-1:0] cnt;

  assign s_tready     = (state == ST_IDLE);
  assign cmd.accept   = (state == ST_IDLE) && s_tvalid;
  assign cmd.div_step = (state == ST_DIVIDE);
  assign cmd.load_out = (state == ST_DONE) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.accept && sts.result) begin
            if (sts.error) begin
              state <= ST_DONE;
            end else begin
              state <= ST_DIVIDE;
              cnt   <= CntW'(DIV_BITS - 1);
            end
          end
        end
        ST_DIVIDE: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/epfm_dp.sv]
// Datapath: tick counter, edge capture, restoring divider and output register.
module epfm_dp #(
  parameter int unsigned COUNTER_BITS = epfm_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [epfm_pkg::TPS_BITS-1:0]       cfg_data,
  input  logic                                rising_edge,
  input  epfm_pkg::cmd_t                      cmd,
  output epfm_pkg::sts_t                      sts,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [epfm_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic [epfm_pkg::STATUS_BITS-1:0]    m_tuser
);
  import epfm_pkg::*;

  logic [TPS_BITS-1:0]     tps;
  logic [COUNTER_BITS-1:0] tick_counter;
  logic [COUNTER_BITS-1:0] first_capture;
  logic                    armed;
  logic                    wrapped;

  logic [COUNTER_BITS-1:0] period_now;
  logic [COUNTER_BITS-1:0] period_r;
  logic [STATUS_BITS-1:0]  status_r;
  logic [DIV_BITS-1:0]     quot;
  logic [COUNTER_BITS-1:0] rem;
  logic [COUNTER_BITS:0]   rem_sh;
  logic [COUNTER_BITS:0]   diff;
  logic [31:0]             period_wide;
  logic [PERIOD_BITS-1:0]  period_shown;
  logic                    result_now;

  assign period_now = tick_counter - first_capture;
  assign result_now = armed && rising_edge;

  assign sts.result   = result_now;
  assign sts.error    = wrapped || (period_now == '0);
  assign sts.out_free = !m_tvalid || m_tready;

  assign rem_sh = {rem, quot[DIV_BITS-1]};
  assign diff   = rem_sh - {1'b0, period_r};

  assign period_wide  = 32'(period_r);
  assign period_shown = (|period_wide[31:PERIOD_BITS]) ? '1 : period_wide[PERIOD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tps           <= TPS_RESET;
      tick_counter  <= '0;
      first_capture <= '0;
      armed         <= 1'b0;
      wrapped       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tps <= cfg_data;
      end
      if (cmd.accept) begin
        if (result_now) begin
          tick_counter  <= '0;
          first_capture <= '0;
          armed         <= 1'b0;
          wrapped       <= 1'b0;
        end else begin
          tick_counter <= tick_counter + COUNTER_BITS'(1);
          if (rising_edge) begin
            first_capture <= tick_counter;
            armed         <= 1'b1;
          end
          wrapped <= (wrapped && !rising_edge) || ((armed || rising_edge) && (&tick_counter));
        end
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && result_now) begin
      period_r <= period_now;
      if (wrapped) begin
        status_r <= STATUS_WRAP;
      end else if (period_now == '0) begin
        status_r <= STATUS_ZERO;
      end else begin
        status_r <= STATUS_OK;
      end
      quot <= {tps, FRAC_BITS'(0)};
      rem  <= '0;
    end else if (cmd.div_step) begin
      if (!diff[COUNTER_BITS]) begin
        rem  <= diff[COUNTER_BITS-1:0];
        quot <= {quot[DIV_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[COUNTER_BITS-1:0];
        quot <= {quot[DIV_BITS-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      if (status_r == STATUS_OK) begin
        m_tdata <= {FREQ_BITS'(quot), period_shown};
      end else begin
        m_tdata <= '0;
      end
      m_tuser <= status_r;
    end
  end

endmodule
